>>> rtl/core/cds_pkg.sv
// Package for the calendar date stepper: payload and control types,
// calendar constants and the small calendar functions.
// No dependencies.
package cds_pkg;

    typedef struct packed {
        logic              action;
        logic [4:0]        day_in;
        logic [3:0]        month_in;
        logic [15:0]       year_in;
        logic signed [7:0] day_count;
    } cds_in_t;

    typedef struct packed {
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [15:0] year_out;
        logic [2:0]  weekday_out;
        logic [8:0]  year_day_out;
        logic        date_ok;
    } cds_out_t;

    typedef logic [3:0] step_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_COUNT,
        OP_WALK,
        OP_WK_YEAR,
        OP_WK_DIV,
        OP_WK_SUM,
        OP_WK_MOD
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_ITEM,
        C_ADD,
        C_BAD_LOAD,
        C_BAD_DATE,
        C_MORE,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        logic  emit;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic item_add;
        logic load_bad;
        logic date_bad;
        logic cnt_more;
        logic out_busy;
    } cds_stat_t;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_ADD  = 1'b1;

    localparam step_t ST_IDLE    = 4'd0;
    localparam step_t ST_SPLIT   = 4'd1;
    localparam step_t ST_LOAD    = 4'd2;
    localparam step_t ST_TO_WK   = 4'd3;
    localparam step_t ST_CHECK   = 4'd4;
    localparam step_t ST_COUNT   = 4'd5;
    localparam step_t ST_WALK    = 4'd6;
    localparam step_t ST_WK_YEAR = 4'd7;
    localparam step_t ST_WK_DIV  = 4'd8;
    localparam step_t ST_WK_SUM  = 4'd9;
    localparam step_t ST_WK_MOD  = 4'd10;
    localparam step_t ST_EMIT    = 4'd11;
    localparam step_t ST_RETRY   = 4'd12;

    localparam logic [15:0] YEAR_BASE   = 16'd2000;
    localparam logic [16:0] YEAR_BIAS   = 17'd400;
    localparam logic [12:0] DIV25_MUL   = 13'd5243;
    localparam int          DIV25_SHIFT = 17;
    localparam int          PROD_W      = 28;
    localparam logic [15:0] INV25       = 16'd23593;
    localparam logic [15:0] DIV25_LIM   = 16'd2621;
    localparam logic [3:0]  DECEMBER    = 4'd12;
    localparam logic [3:0]  MARCH       = 4'd3;
    localparam logic [2:0]  WEEK_DAYS   = 3'd7;

    function automatic logic is_leap(input logic [15:0] y);
        logic [31:0] p;
        logic        by25;
        p    = 32'(y) * 32'(INV25);
        by25 = (p[15:0] <= DIV25_LIM);
        return (y[1:0] == 2'd0) && (!by25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                       len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:         len = 5'd31;
            default:                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic date_valid(input logic [4:0] d, input logic [3:0] m,
                                        input logic leap);
        return (m >= 4'd1) && (m <= DECEMBER) && (d >= 5'd1) && (d <= month_len(m, leap));
    endfunction

    function automatic logic [2:0] month_offset(input logic [3:0] m);
        logic [2:0] off;
        unique case (m)
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        unique case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // fold octal digits: 8 is 1 modulo 7
    function automatic logic [2:0] mod7(input logic [16:0] s);
        logic [5:0] f1;
        logic [3:0] f2;
        logic [3:0] f3;
        f1 = {3'b0, s[2:0]} + {3'b0, s[5:3]} + {3'b0, s[8:6]} + {3'b0, s[11:9]}
           + {3'b0, s[14:12]} + {4'b0, s[16:15]};
        f2 = {1'b0, f1[2:0]} + {1'b0, f1[5:3]};
        f3 = {1'b0, f2[2:0]} + {3'b0, f2[3]};
        if (f3 >= {1'b0, WEEK_DAYS}) begin
            f3 = f3 - {1'b0, WEEK_DAYS};
        end
        return f3[2:0];
    endfunction

    function automatic ucode_t rom_word(input step_t s);
        ucode_t w;
        unique case (s)
            ST_IDLE:    w = '{OP_NOP,     1'b0, C_NO_ITEM,  ST_IDLE};
            ST_SPLIT:   w = '{OP_NOP,     1'b0, C_ADD,      ST_CHECK};
            ST_LOAD:    w = '{OP_LOAD,    1'b0, C_BAD_LOAD, ST_EMIT};
            ST_TO_WK:   w = '{OP_NOP,     1'b0, C_ALWAYS,   ST_WK_YEAR};
            ST_CHECK:   w = '{OP_NOP,     1'b0, C_BAD_DATE, ST_EMIT};
            ST_COUNT:   w = '{OP_COUNT,   1'b0, C_NEXT,     ST_IDLE};
            ST_WALK:    w = '{OP_WALK,    1'b0, C_MORE,     ST_WALK};
            ST_WK_YEAR: w = '{OP_WK_YEAR, 1'b0, C_NEXT,     ST_IDLE};
            ST_WK_DIV:  w = '{OP_WK_DIV,  1'b0, C_NEXT,     ST_IDLE};
            ST_WK_SUM:  w = '{OP_WK_SUM,  1'b0, C_NEXT,     ST_IDLE};
            ST_WK_MOD:  w = '{OP_WK_MOD,  1'b0, C_NEXT,     ST_IDLE};
            ST_EMIT:    w = '{OP_NOP,     1'b1, C_OUT_FREE, ST_IDLE};
            ST_RETRY:   w = '{OP_NOP,     1'b0, C_ALWAYS,   ST_EMIT};
            default:    w = '{OP_NOP,     1'b0, C_ALWAYS,   ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/calendar_date_stepper.sv
// Calendar date stepper: holds one Gregorian date and loads it or moves it
// by a signed day count. Uses cds_pkg, cds_useq and cds_datapath.
//
// Each accepted item returns one result with the stored date, its weekday
// (1 Sunday to 7 Saturday), its ordinal day and a valid flag. A load item
// adds 2000 to years below 2000 and clears the store on a date that does not
// exist; an add item on a cleared store changes nothing. A small program in
// a control store sequences the work: a valid load computes the weekday,
// an add walks the date by |day_count| days, one day per cycle, before the
// weekday step, and a load of a date that does not exist or an add on a
// cleared store goes straight to the result. The input is taken again
// once the result sits in the output register, so a stalled result holds
// at most one item back.
module calendar_date_stepper
    import cds_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cds_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cds_out_t m_data
);

    ucode_t    ctrl;
    cds_stat_t stat;
    logic      accept;

    assign accept = s_valid && s_ready;

    cds_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .ctrl    (ctrl),
        .s_ready (s_ready)
    );

    cds_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .s_data  (s_data),
        .ctrl    (ctrl),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/core/cds_useq.sv
// Step counter and control store for the calendar date stepper.
// Depends on cds_pkg (control word, conditions, program).
module cds_useq
    import cds_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  cds_stat_t stat,
    output ucode_t    ctrl,
    output logic      s_ready
);

    step_t  step_reg;
    step_t  step_next;
    logic   taken;

    always_comb begin
        ctrl = rom_word(step_reg);
        unique case (ctrl.cond)
            C_NEXT:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_ITEM:  taken = !s_valid;
            C_ADD:      taken = stat.item_add;
            C_BAD_LOAD: taken = stat.load_bad;
            C_BAD_DATE: taken = stat.date_bad;
            C_MORE:     taken = stat.cnt_more;
            C_OUT_FREE: taken = !stat.out_busy;
            default:    taken = 1'b0;
        endcase
        step_next = taken ? ctrl.target : step_reg + 4'd1;
        s_ready   = (step_reg == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

>>> rtl/core/cds_datapath.sv
// Date store, day walker, weekday arithmetic and result register.
// Depends on cds_pkg; driven by the control word from cds_useq.
module cds_datapath
    import cds_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      accept,
    input  cds_in_t   s_data,
    input  ucode_t    ctrl,
    output cds_stat_t stat,
    output logic      m_valid,
    input  logic      m_ready,
    output cds_out_t  m_data
);

    cds_in_t            item_reg;
    logic               leap_in_reg;
    logic               leap_reg;
    logic [4:0]         day_reg,     day_next;
    logic [3:0]         month_reg,   month_next;
    logic [15:0]        year_reg,    year_next;
    logic [2:0]         weekday_reg, weekday_next;
    logic [7:0]         cnt_reg,     cnt_next;
    logic               dir_reg,     dir_next;
    logic [16:0]        yy_reg,      yy_next;
    logic [PROD_W-1:0]  prod_reg,    prod_next;
    logic [16:0]        sum_reg,     sum_next;
    logic               m_valid_reg, m_valid_next;
    cds_out_t           out_reg,     out_next;

    logic [15:0]        year_adj;
    cds_in_t            item_in;
    logic               load_ok;
    logic               date_ok_now;
    logic [4:0]         cur_len;
    logic [3:0]         prev_month;
    logic [15:0]        prev_year;
    logic [10:0]        q100;
    logic               do_emit;

    always_comb begin
        year_adj    = (s_data.year_in < YEAR_BASE) ? s_data.year_in + YEAR_BASE
                                                   : s_data.year_in;
        item_in         = s_data;
        item_in.year_in = year_adj;
        load_ok     = date_valid(item_reg.day_in, item_reg.month_in, leap_in_reg);
        date_ok_now = date_valid(day_reg, month_reg, leap_reg);
        cur_len     = month_len(month_reg, leap_reg);
        prev_month  = (month_reg > 4'd1) ? month_reg - 4'd1 : DECEMBER;
        prev_year   = (month_reg > 4'd1) ? year_reg : year_reg - 16'd1;
        q100        = prod_reg[PROD_W-1:DIV25_SHIFT];

        stat.item_add = (item_reg.action == ACT_ADD);
        stat.load_bad = !load_ok;
        stat.date_bad = !date_ok_now;
        stat.cnt_more = (cnt_reg > 8'd1);
        stat.out_busy = m_valid_reg && !m_ready;

        do_emit     = ctrl.emit && !stat.out_busy;

        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        weekday_next = weekday_reg;
        cnt_next     = cnt_reg;
        dir_next     = dir_reg;
        yy_next      = yy_reg;
        prod_next    = prod_reg;
        sum_next     = sum_reg;

        unique case (ctrl.op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                if (load_ok) begin
                    day_next   = item_reg.day_in;
                    month_next = item_reg.month_in;
                    year_next  = item_reg.year_in;
                end else begin
                    day_next     = '0;
                    month_next   = '0;
                    year_next    = '0;
                    weekday_next = '0;
                end
            end
            OP_COUNT: begin
                dir_next = item_reg.day_count[7];
                cnt_next = item_reg.day_count[7] ? 8'(-item_reg.day_count)
                                                 : 8'(item_reg.day_count);
            end
            OP_WALK: begin
                if (cnt_reg != 8'd0) begin
                    cnt_next = cnt_reg - 8'd1;
                    if (!dir_reg) begin
                        if (day_reg >= cur_len) begin
                            day_next = 5'd1;
                            if (month_reg == DECEMBER) begin
                                month_next = 4'd1;
                                year_next  = year_reg + 16'd1;
                            end else begin
                                month_next = month_reg + 4'd1;
                            end
                        end else begin
                            day_next = day_reg + 5'd1;
                        end
                    end else begin
                        if (day_reg > 5'd1) begin
                            day_next = day_reg - 5'd1;
                        end else begin
                            month_next = prev_month;
                            year_next  = prev_year;
                            day_next   = month_len(prev_month, leap_reg);
                        end
                    end
                end
            end
            OP_WK_YEAR: begin
                yy_next = {1'b0, year_reg} + YEAR_BIAS - {16'b0, (month_reg < MARCH)};
            end
            OP_WK_DIV: begin
                prod_next = PROD_W'(yy_reg[16:2]) * PROD_W'(DIV25_MUL);
            end
            OP_WK_SUM: begin
                sum_next = yy_reg + {2'b0, yy_reg[16:2]} - {6'b0, q100}
                         + {8'b0, q100[10:2]} + {14'b0, month_offset(month_reg)}
                         + {12'b0, day_reg};
            end
            OP_WK_MOD: begin
                weekday_next = mod7(sum_reg) + 3'd1;
            end
            default: begin
            end
        endcase

        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (do_emit) begin
            m_valid_next         = 1'b1;
            out_next.day_out     = day_reg;
            out_next.month_out   = month_reg;
            out_next.year_out    = year_reg;
            out_next.date_ok     = date_ok_now;
            out_next.weekday_out = date_ok_now ? weekday_reg : 3'd0;
            out_next.year_day_out = date_ok_now
                ? days_before(month_reg) + {8'b0, (leap_reg && month_reg >= MARCH)}
                  + {4'b0, day_reg}
                : 9'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg     <= '0;
            month_reg   <= '0;
            year_reg    <= '0;
            weekday_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
            weekday_reg <= weekday_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_in;
        end
        leap_in_reg <= is_leap(item_reg.year_in);
        leap_reg    <= is_leap(year_reg);
        cnt_reg     <= cnt_next;
        dir_reg     <= dir_next;
        yy_reg      <= yy_next;
        prod_reg    <= prod_next;
        sum_reg     <= sum_next;
        out_reg     <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> rtl/core/cds_checker.sv
// Port-level checks for the calendar date stepper, bound to the top level.
// Depends on cds_pkg and calendar_date_stepper.
module cds_checker
    import cds_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input cds_out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed before its transfer");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    a_result_after_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result raised with no item in flight");

    a_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.date_ok |-> m_data.day_out == 5'd0 && m_data.month_out == 4'd0
            && m_data.year_out == 16'd0 && m_data.weekday_out == 3'd0
            && m_data.year_day_out == 9'd0)
        else $error("invalid date with non-zero fields");

    a_valid_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.date_ok |-> m_data.month_out != 4'd0 && m_data.month_out <= DECEMBER
            && m_data.day_out != 5'd0 && m_data.weekday_out != 3'd0
            && m_data.year_day_out != 9'd0)
        else $error("valid date with out-of-range fields");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (.*);
